FILE: src/gne_pkg.sv
package gne_pkg;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    CFG_SHAPE  = 3'd0,
    CFG_REACH  = 3'd1,
    CFG_EDGE   = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4
  } gne_cfg_e;

  typedef enum logic [1:0] {
    TBL_MOORE1,
    TBL_MOORE2,
    TBL_VN1,
    TBL_VN2
  } gne_table_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } gne_state_e;

  typedef struct packed {
    logic signed [2:0] dx;
    logic signed [2:0] dy;
  } gne_offset_t;

  typedef struct packed {
    logic               keep;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
  } gne_step_t;

  localparam logic signed [2:0] M1_DX [8] = '{-3'sd1, 3'sd0, 3'sd1, -3'sd1, 3'sd1,
                                               -3'sd1, 3'sd0, 3'sd1};
  localparam logic signed [2:0] M1_DY [8] = '{3'sd1, 3'sd1, 3'sd1, 3'sd0, 3'sd0,
                                               -3'sd1, -3'sd1, -3'sd1};

  localparam logic signed [2:0] M2_DX [24] = '{
    -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2,
    -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2,
    -3'sd2, -3'sd1, 3'sd1, 3'sd2,
    -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2,
    -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2};
  localparam logic signed [2:0] M2_DY [24] = '{
    3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd2,
    3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd1,
    3'sd0, 3'sd0, 3'sd0, 3'sd0,
    -3'sd1, -3'sd1, -3'sd1, -3'sd1, -3'sd1,
    -3'sd2, -3'sd2, -3'sd2, -3'sd2, -3'sd2};

  localparam logic signed [2:0] V1_DX [4] = '{3'sd0, -3'sd1, 3'sd1, 3'sd0};
  localparam logic signed [2:0] V1_DY [4] = '{3'sd1, 3'sd0, 3'sd0, -3'sd1};

  localparam logic signed [2:0] V2_DX [12] = '{3'sd0, -3'sd1, 3'sd0, 3'sd1, -3'sd2, -3'sd1,
                                                3'sd1, 3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd0};
  localparam logic signed [2:0] V2_DY [12] = '{3'sd2, 3'sd1, 3'sd1, 3'sd1, 3'sd0, 3'sd0,
                                                3'sd0, 3'sd0, -3'sd1, -3'sd1, -3'sd1, -3'sd2};

  // Offset lookup; in the reach-two tables, indexes past the table end read as zero offset.
  function automatic gne_offset_t gne_offset(gne_table_e tbl, logic [IDX_W-1:0] idx);
    gne_offset_t o;
    o = '0;
    case (tbl)
      TBL_MOORE1: begin
        o.dx = M1_DX[idx[2:0]];
        o.dy = M1_DY[idx[2:0]];
      end
      TBL_MOORE2: begin
        if (idx < IDX_W'(24)) begin
          o.dx = M2_DX[idx];
          o.dy = M2_DY[idx];
        end
      end
      TBL_VN1: begin
        o.dx = V1_DX[idx[1:0]];
        o.dy = V1_DY[idx[1:0]];
      end
      TBL_VN2: begin
        if (idx < IDX_W'(12)) begin
          o.dx = V2_DX[idx[3:0]];
          o.dy = V2_DY[idx[3:0]];
        end
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic logic [IDX_W-1:0] gne_last_idx(gne_table_e tbl);
    logic [IDX_W-1:0] r;
    case (tbl)
      TBL_MOORE1: r = IDX_W'(7);
      TBL_MOORE2: r = IDX_W'(23);
      TBL_VN1:    r = IDX_W'(3);
      TBL_VN2:    r = IDX_W'(11);
      default:    r = IDX_W'(7);
    endcase
    return r;
  endfunction

endpackage

FILE: src/gne_step.sv
module gne_step (
  input  logic [gne_pkg::COORD_W-1:0] px_i,
  input  logic [gne_pkg::COORD_W-1:0] py_i,
  input  gne_pkg::gne_offset_t        off_i,
  input  logic [gne_pkg::DIM_W-1:0]   wd_i,
  input  logic [gne_pkg::DIM_W-1:0]   ht_i,
  input  logic                        torus_i,
  output gne_pkg::gne_step_t          step_o
);

  localparam int unsigned SUM_W = gne_pkg::DIM_W + 1;

  logic [SUM_W-1:0] sx, sy, wx, wy;
  logic             out_x, out_y;

  // Add the offset, then wrap once by the dimension when out of range.
  function automatic logic [SUM_W-1:0] axis_sum(logic [gne_pkg::COORD_W-1:0] p,
                                                 logic signed [2:0] d);
    return SUM_W'(p) + SUM_W'($signed(d));
  endfunction

  function automatic logic axis_out(logic [SUM_W-1:0] s, logic [gne_pkg::DIM_W-1:0] dim);
    return s[SUM_W-1] || (s[gne_pkg::DIM_W-1:0] >= dim);
  endfunction

  function automatic logic [SUM_W-1:0] axis_wrap(logic [SUM_W-1:0] s,
                                                  logic [gne_pkg::DIM_W-1:0] dim);
    logic [SUM_W-1:0] r;
    if (s[SUM_W-1]) begin
      r = s + SUM_W'(dim);
    end else if (s[gne_pkg::DIM_W-1:0] >= dim) begin
      r = s - SUM_W'(dim);
    end else begin
      r = s;
    end
    return r;
  endfunction

  always_comb begin
    sx    = axis_sum(px_i, off_i.dx);
    sy    = axis_sum(py_i, off_i.dy);
    out_x = axis_out(sx, wd_i);
    out_y = axis_out(sy, ht_i);
    wx    = axis_wrap(sx, wd_i);
    wy    = axis_wrap(sy, ht_i);
    step_o.keep = torus_i || !(out_x || out_y);
    step_o.nx   = wx[gne_pkg::COORD_W-1:0];
    step_o.ny   = wy[gne_pkg::COORD_W-1:0];
  end

endmodule

FILE: src/grid_neighbor_enumerator_top.sv
// Grid neighbor enumerator.
// Input channel (in_valid_i / in_stall_o) carries one centre point per
// transaction. The block then walks the offset table of the configured
// neighborhood (Moore or von Neumann, reach one or two: 8, 24, 4 or 12
// offsets), one offset per cycle through a shared step unit unless the walk pauses, and emits
// one result transaction per kept neighbor on the output channel
// (out_valid_o / out_stall_i). Offsets off the grid are skipped in
// hard-wall mode and wrapped once by the dimension in torus mode. The
// final kept neighbor carries last_neighbor; a point with no kept
// neighbor yields no result.
// A new point is accepted only once the walk and flush of the previous one
// have ended. A kept neighbor waits in a hold register until the next kept
// neighbor or the final flush pushes it to the output register, so
// skipped offsets delay the first result.
// in_stall_o stays high while a point is walked.
// A stalled output holds its result, and the walk pauses on the next kept
// neighbor until the output register frees.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready and should be
// written only while idle. Reset clears the sequencer and output valid and
// loads the register defaults (Moore, reach one, torus, 1024 x 1024).
module grid_neighbor_enumerator_top #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gne_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gne_pkg::DIM_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gne_pkg::COORD_W-1:0]     point_x_i,
  input  logic [gne_pkg::COORD_W-1:0]     point_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gne_pkg::COORD_W-1:0]     neighbor_x_o,
  output logic [gne_pkg::COORD_W-1:0]     neighbor_y_o,
  output logic [gne_pkg::IDX_W-1:0]       offset_index_o,
  output logic                            last_neighbor_o
);

  localparam int unsigned DIM_W   = gne_pkg::DIM_W;
  localparam int unsigned COORD_W = gne_pkg::COORD_W;
  localparam int unsigned IDX_W   = gne_pkg::IDX_W;

  // Configuration registers
  logic             shape_q, reach_q, edge_q;
  logic [DIM_W-1:0] width_q, height_q;

  // Per-point working registers
  gne_pkg::gne_state_e state_q, state_d;
  gne_pkg::gne_table_e tbl_q;
  logic [COORD_W-1:0]  px_q, py_q;
  logic [DIM_W-1:0]    wd_q, ht_q;
  logic                torus_q;
  logic [IDX_W-1:0]    idx_q, last_idx_q;

  // One-deep hold of the latest kept neighbor, so the last flag is known
  logic               pend_valid_q;
  logic [COORD_W-1:0] pend_x_q, pend_y_q;
  logic [IDX_W-1:0]   pend_idx_q;

  // Output register
  logic               out_valid_q;
  logic [COORD_W-1:0] out_x_q, out_y_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic               out_last_q;

  logic                 accept;
  logic                 out_free;
  logic                 run_go;
  logic                 push;
  logic                 push_last;
  gne_pkg::gne_table_e  tbl_sel;
  gne_pkg::gne_offset_t offset;
  gne_pkg::gne_step_t   step;

  assign cfg_ready_o = 1'b1;

  // Clamp a dimension into [2, MAX_DIM].
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d < DIM_W'(2)) begin
      r = DIM_W'(2);
    end else if (32'(d) > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= 1'b0;
      reach_q  <= 1'b0;
      edge_q   <= 1'b1;
      width_q  <= DIM_W'(1024);
      height_q <= DIM_W'(1024);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gne_pkg::CFG_SHAPE:  shape_q  <= cfg_data_i[0];
        gne_pkg::CFG_REACH:  reach_q  <= cfg_data_i[0];
        gne_pkg::CFG_EDGE:   edge_q   <= cfg_data_i[0];
        gne_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        gne_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case ({shape_q, reach_q})
      2'b00:   tbl_sel = gne_pkg::TBL_MOORE1;
      2'b01:   tbl_sel = gne_pkg::TBL_MOORE2;
      2'b10:   tbl_sel = gne_pkg::TBL_VN1;
      2'b11:   tbl_sel = gne_pkg::TBL_VN2;
      default: tbl_sel = gne_pkg::TBL_MOORE1;
    endcase
  end

  // Shared step unit: one offset per cycle unless the walk pauses
  assign offset = gne_pkg::gne_offset(tbl_q, idx_q);

  gne_step u_step (
    .px_i    (px_q),
    .py_i    (py_q),
    .off_i   (offset),
    .wd_i    (wd_q),
    .ht_i    (ht_q),
    .torus_i (torus_q),
    .step_o  (step)
  );

  // Sequencer outputs
  always_comb begin
    out_free  = !out_valid_q || !out_stall_i;
    accept    = in_valid_i && (state_q == gne_pkg::ST_IDLE);
    run_go    = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    case (state_q)
      gne_pkg::ST_RUN: begin
        // Stall the walk only when a kept neighbor must displace the held one
        run_go = !(step.keep && pend_valid_q && !out_free);
        push   = run_go && step.keep && pend_valid_q;
      end
      gne_pkg::ST_FLUSH: begin
        push      = pend_valid_q && out_free;
        push_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != gne_pkg::ST_IDLE);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gne_pkg::ST_IDLE: begin
        if (accept) state_d = gne_pkg::ST_RUN;
      end
      gne_pkg::ST_RUN: begin
        if (run_go && (idx_q == last_idx_q)) state_d = gne_pkg::ST_FLUSH;
      end
      gne_pkg::ST_FLUSH: begin
        if (!pend_valid_q || out_free) state_d = gne_pkg::ST_IDLE;
      end
      default: state_d = gne_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gne_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the point and a snapshot of the geometry on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q       <= point_x_i;
      py_q       <= point_y_i;
      tbl_q      <= tbl_sel;
      last_idx_q <= gne_pkg::gne_last_idx(tbl_sel);
      wd_q       <= clamp_dim(width_q);
      ht_q       <= clamp_dim(height_q);
      torus_q    <= edge_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (accept) begin
      idx_q <= '0;
    end else if (run_go) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // Hold register: replace on each kept neighbor, drop once flushed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (run_go && step.keep) begin
      pend_valid_q <= 1'b1;
    end else if ((state_q == gne_pkg::ST_FLUSH) && push) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_go && step.keep) begin
      pend_x_q   <= step.nx;
      pend_y_q   <= step.ny;
      pend_idx_q <= idx_q;
    end
  end

  // Output register: load on push, clear once the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_x_q    <= pend_x_q;
      out_y_q    <= pend_y_q;
      out_idx_q  <= pend_idx_q;
      out_last_q <= push_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign neighbor_x_o    = out_x_q;
  assign neighbor_y_o    = out_y_q;
  assign offset_index_o  = out_idx_q;
  assign last_neighbor_o = out_last_q;

endmodule

FILE: tb/neighbor_checker.sv
`timescale 1ns / 1ps

module neighbor_checker
  import gne_pkg::*;
#(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [COORD_W-1:0]   point_x_i,
  input  logic [COORD_W-1:0]   point_y_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [COORD_W-1:0]   neighbor_x_i,
  input  logic [COORD_W-1:0]   neighbor_y_i,
  input  logic [IDX_W-1:0]     offset_index_i,
  input  logic                 last_neighbor_i,
  output int                   pending_o,
  output int                   error_count_o
);

  typedef struct packed {
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [IDX_W-1:0]   idx;
    logic               last;
  } neighbor_t;

  neighbor_t        expected_neighbors[$];
  neighbor_t        got;
  neighbor_t        want;
  int               errors = 0;
  logic             shape_q;
  logic             reach_q;
  logic             wrap_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;

  assign error_count_o = errors;

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got_v, want_v, $time);
    errors++;
  endtask

  function automatic int clamp_dim(input logic [DIM_W-1:0] d);
    if (d < 2) return 2;
    if (d > MAX_DIM) return int'(MAX_DIM);
    return int'(d);
  endfunction

  // Walk the neighborhood row by row, north to south and west to east, and
  // queue one entry per neighbor that survives the boundary rule.
  function automatic void predict_neighbors(input logic [COORD_W-1:0] px,
                                            input logic [COORD_W-1:0] py);
    gne_table_e tbl;
    int         r;
    int         wd;
    int         ht;
    int         nx;
    int         ny;
    int         slot;
    int         kept;
    bit         diamond;
    bit         keep;
    neighbor_t  nb;
    if (shape_q) tbl = reach_q ? TBL_VN2 : TBL_VN1;
    else tbl = reach_q ? TBL_MOORE2 : TBL_MOORE1;
    r       = (tbl == TBL_MOORE2 || tbl == TBL_VN2) ? 2 : 1;
    diamond = (tbl == TBL_VN1 || tbl == TBL_VN2);
    wd      = clamp_dim(width_q);
    ht      = clamp_dim(height_q);
    slot    = 0;
    kept    = 0;
    for (int dy = r; dy >= -r; dy--) begin
      for (int dx = -r; dx <= r; dx++) begin
        if (!(dx == 0 && dy == 0) &&
            (!diamond || ((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy)) <= r)) begin
          nx   = int'(px) + dx;
          ny   = int'(py) + dy;
          keep = 1'b1;
          if (!wrap_q) begin
            if (nx < 0 || nx >= wd || ny < 0 || ny >= ht) keep = 1'b0;
          end else begin
            if (nx < 0) nx += wd;
            else if (nx >= wd) nx -= wd;
            if (ny < 0) ny += ht;
            else if (ny >= ht) ny -= ht;
          end
          if (keep) begin
            nb.nx   = nx[COORD_W-1:0];
            nb.ny   = ny[COORD_W-1:0];
            nb.idx  = slot[IDX_W-1:0];
            nb.last = 1'b0;
            expected_neighbors.insert(expected_neighbors.size(), nb);
            kept++;
          end
          slot++;
        end
      end
    end
    if (kept > 0) expected_neighbors[expected_neighbors.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  = 1'b0;
      reach_q  = 1'b0;
      wrap_q   = 1'b1;
      width_q  = DIM_W'(1024);
      height_q = DIM_W'(1024);
      expected_neighbors.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (gne_cfg_e'(cfg_index_i))
          CFG_SHAPE:  shape_q  = cfg_data_i[0];
          CFG_REACH:  reach_q  = cfg_data_i[0];
          CFG_EDGE:   wrap_q   = cfg_data_i[0];
          CFG_WIDTH:  width_q  = cfg_data_i;
          CFG_HEIGHT: height_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_neighbors(point_x_i, point_y_i);
      if (out_valid_i && !out_stall_i) begin
        got = '{neighbor_x_i, neighbor_y_i, offset_index_i, last_neighbor_i};
        if (expected_neighbors.size() == 0) begin
          report_mismatch("unexpected result, offset_index", int'(got.idx), -1);
        end else begin
          want = expected_neighbors.pop_front();
          if (got.nx != want.nx) report_mismatch("neighbor_x", int'(got.nx), int'(want.nx));
          if (got.ny != want.ny) report_mismatch("neighbor_y", int'(got.ny), int'(want.ny));
          if (got.idx != want.idx)
            report_mismatch("offset_index", int'(got.idx), int'(want.idx));
          if (got.last != want.last)
            report_mismatch("last_neighbor", int'(got.last), int'(want.last));
        end
      end
      pending_o <= expected_neighbors.size();
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gne_pkg::*;

  localparam int unsigned MAX_DIM = 1024;
  localparam int LIMIT_CYCLES = 500000;
  // Longest walk is 24 offsets plus the sequencer overhead; allow margin
  // for a point whose every neighbor is dropped.
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int SEGMENT_ITEMS = 17;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = '0;
  logic [DIM_W-1:0]     cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [COORD_W-1:0]   point_x_i       = '0;
  logic [COORD_W-1:0]   point_y_i       = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [COORD_W-1:0]   neighbor_x_o;
  logic [COORD_W-1:0]   neighbor_y_o;
  logic [IDX_W-1:0]     offset_index_o;
  logic                 last_neighbor_o;

  int   pending;
  int   errors;
  int   cycle_count   = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic long_hold     = 1'b0;

  grid_neighbor_enumerator_top #(.MAX_DIM(MAX_DIM)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .neighbor_x_o    (neighbor_x_o),
    .neighbor_y_o    (neighbor_y_o),
    .offset_index_o  (offset_index_o),
    .last_neighbor_o (last_neighbor_o)
  );

  neighbor_checker #(.MAX_DIM(MAX_DIM)) u_neighbor_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .neighbor_x_i    (neighbor_x_o),
    .neighbor_y_i    (neighbor_y_o),
    .offset_index_i  (offset_index_o),
    .last_neighbor_i (last_neighbor_o),
    .pending_o       (pending),
    .error_count_o   (errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stall, or a solid stall while a long hold is active.
  always @(negedge clk_i) begin
    out_stall_i <= long_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one point and hold it until the block takes it; return at the
  // falling edge after the transaction with valid still high.
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i  <= x;
    point_y_i  <= y;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every predicted neighbor, then let a silent walk
  // (all offsets dropped) run out before touching the registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic shape, input logic reach, input logic wrap,
                           input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_write(CFG_SHAPE, DIM_W'(shape));
    cfg_write(CFG_REACH, DIM_W'(reach));
    cfg_write(CFG_EDGE, DIM_W'(wrap));
    cfg_write(CFG_WIDTH, w);
    cfg_write(CFG_HEIGHT, h);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return DIM_W'($urandom_range(40, 2));
      6:                return DIM_W'($urandom_range(1));
      7:                return DIM_W'(1024);
      8:                return DIM_W'($urandom_range(2047, 1025));
      default:          return DIM_W'($urandom_range(1024, 2));
    endcase
  endfunction

  // Favor points on and next to the border, where skip and wrap happen.
  function automatic logic [COORD_W-1:0] pick_coord(input int dim);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return COORD_W'($urandom_range(dim - 1));
      5:             return '0;
      6:             return COORD_W'(1);
      7:             return COORD_W'(dim - $urandom_range(2, 1));
      8:             return COORD_W'($urandom_range(1023));
      default:       return '1;
    endcase
  endfunction

  task automatic run_segment(input bit with_hold);
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    int               wd;
    int               ht;
    w  = pick_dim();
    h  = pick_dim();
    wd = (w < 2) ? 2 : ((w > MAX_DIM) ? int'(MAX_DIM) : int'(w));
    ht = (h < 2) ? 2 : ((h > MAX_DIM) ? int'(MAX_DIM) : int'(h));
    configure(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)), w, h);
    if (with_hold) begin
      // Stall results for a long stretch while points keep coming, so the
      // block backs up and stalls its input.
      fork
        begin
          long_hold <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          long_hold <= 1'b0;
        end
      join_none
    end
    repeat (SEGMENT_ITEMS) send_point(pick_coord(wd), pick_coord(ht));
    drain();
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: Moore reach one, torus, 1024 x 1024; corners wrap.
    send_point('0, '0);
    send_point('1, '1);
    send_point('0, '1);
    send_point('1, '0);
    send_point(COORD_W'(512), COORD_W'(511));
    drain();

    // Diamond reach two, hard walls; oversized width and undersized height
    // are clamped. The last point sits outside the grid and yields nothing.
    configure(1'b1, 1'b1, 1'b0, '1, DIM_W'(1));
    send_point('0, '0);
    send_point(COORD_W'(1), COORD_W'(1));
    send_point('1, COORD_W'(1));
    send_point('1, COORD_W'(5));
    drain();

    // Moore reach two on a 2 x 3 torus, plus a point outside the grid.
    configure(1'b0, 1'b1, 1'b1, DIM_W'(2), DIM_W'(3));
    send_point('0, '0);
    send_point(COORD_W'(1), COORD_W'(2));
    send_point('1, '1);
    drain();

    // Diamond reach one, hard walls, full grid; writes past the register
    // list must not disturb anything.
    configure(1'b1, 1'b0, 1'b0, DIM_W'(1024), DIM_W'(1024));
    for (int i = int'(CFG_HEIGHT) + 1; i < (1 << CFG_IDX_W); i++) cfg_write(i[CFG_IDX_W-1:0], '1);
    send_point('0, '0);
    send_point('1, '1);
    drain();

    // Zero dimensions clamp to 2; a point far outside drops every offset.
    configure(1'b0, 1'b0, 1'b0, '0, '0);
    send_point('0, '0);
    send_point(COORD_W'(1), COORD_W'(1));
    send_point(COORD_W'(5), COORD_W'(5));
    drain();

    // Random segments under three idle profiles.
    send_idle_pct <= 15;
    recv_idle_pct <= 86;
    @(negedge clk_i);
    run_segment(1'b1);
    run_segment(1'b0);
    send_idle_pct <= 86;
    recv_idle_pct <= 15;
    @(negedge clk_i);
    run_segment(1'b0);
    run_segment(1'b0);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    @(negedge clk_i);
    run_segment(1'b0);
    run_segment(1'b0);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/gne_pkg.sv
src/gne_step.sv
src/grid_neighbor_enumerator_top.sv
tb/neighbor_checker.sv
tb/testbench.sv
